[src/pobp_pkg.sv]
package pobp_pkg;

  localparam int COORD_W   = 32;
  localparam int FRAC_BITS = 16;
  localparam int UW        = COORD_W - 1;
  localparam int XW        = COORD_W + 4;
  localparam int PW        = 2 * COORD_W;
  localparam int NUM_W     = 2 * UW;
  localparam int CNT_W     = $clog2(NUM_W);
  localparam int IDX_W     = 3;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [IDX_W-1:0] CFG_KIND   = 3'd0;
  localparam logic [IDX_W-1:0] CFG_CX     = 3'd1;
  localparam logic [IDX_W-1:0] CFG_CY     = 3'd2;
  localparam logic [IDX_W-1:0] CFG_CZ     = 3'd3;
  localparam logic [IDX_W-1:0] CFG_RADIUS = 3'd4;
  localparam logic [IDX_W-1:0] CFG_LENGTH = 3'd5;
  localparam logic [IDX_W-1:0] CFG_SCALE  = 3'd6;

  typedef enum logic [1:0] {
    KIND_SPHERE,
    KIND_CAPSULE,
    KIND_PYRAMID,
    KIND_NONE
  } kind_t;

  typedef enum logic [2:0] {
    OP_PASS,
    OP_SPHERE,
    OP_CAP_SIDE,
    OP_CAP_END,
    OP_PYR
  } op_t;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_TOP,
    PH_BOT
  } phase_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_SETUP,
    B_MAG,
    B_SQ,
    B_CHECK,
    B_SQRT,
    B_MUL,
    B_DIV,
    B_ROUND,
    B_BEND,
    B_PMUL0,
    B_PMUL1,
    B_PDEC,
    B_DONE
  } back_state_t;

  typedef struct packed {
    kind_t                     kind;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic [UW-1:0]             radius;
    logic [UW-1:0]             length;
    logic [UW-1:0]             scale;
  } cfg_t;

  typedef struct packed {
    op_t                       op;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
    logic [1:0]                best;
    logic [UW-1:0]             by;
    logic [COORD_W-1:0]        s;
  } job_t;

  function automatic logic signed [XW-1:0] sx(input logic signed [COORD_W-1:0] v);
    return {{(XW-COORD_W){v[COORD_W-1]}}, v};
  endfunction

  function automatic logic signed [XW-1:0] ux(input logic [UW-1:0] v);
    return {{(XW-UW){1'b0}}, v};
  endfunction

  function automatic logic signed [COORD_W-1:0] sat(input logic signed [XW-1:0] v);
    logic all_one;
    logic all_zero;
    all_one  = &v[XW-1:COORD_W-1];
    all_zero = ~|v[XW-1:COORD_W-1];
    if (all_one || all_zero) begin
      return v[COORD_W-1:0];
    end else if (v[XW-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

endpackage

[src/pobp_fifo.sv]
module pobp_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pobp_pkg::job_t wdata,
  input  logic           pop,
  output pobp_pkg::job_t rdata,
  output logic           empty,
  output logic           full
);
  import pobp_pkg::*;

  job_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp;
  logic [FIFO_AW-1:0] rp;
  logic [FIFO_AW:0]   cnt;

  assign empty = (cnt == '0);
  assign full  = (cnt == (FIFO_AW+1)'(FIFO_DEPTH));
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wdata;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= (FIFO_AW+1)'(FIFO_DEPTH)) else $error("queue count overflow");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    !(push && full)) else $error("push into full queue");
  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty)) else $error("pop from empty queue");

endmodule

[src/pobp_front.sv]
module pobp_front (
  input  logic                               clk,
  input  logic                               rst,
  input  pobp_pkg::cfg_t                     cfg,
  input  logic signed [pobp_pkg::COORD_W-1:0] pos_x,
  input  logic signed [pobp_pkg::COORD_W-1:0] pos_y,
  input  logic signed [pobp_pkg::COORD_W-1:0] pos_z,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               full,
  output logic                               push,
  output pobp_pkg::job_t                     job
);
  import pobp_pkg::*;

  logic                      f_valid;
  logic signed [COORD_W-1:0] fx, fy, fz;
  logic signed [XW-1:0]      dx, dy, dz, qy;
  logic                      accept;

  assign in_stall = f_valid && full;
  assign accept   = in_valid && !in_stall;
  assign push     = f_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fx <= pos_x;
      fy <= pos_y;
      fz <= pos_z;
      dx <= sx(pos_x) - sx(cfg.cx);
      dy <= sx(pos_y) - sx(cfg.cy);
      dz <= sx(pos_z) - sx(cfg.cz);
      qy <= sx(pos_y) - sx(cfg.cy) - ux(cfg.scale);
    end
  end

  // classify: capsule band, pyramid inside test and nearest face
  always_comb begin
    logic signed [XW-1:0] ady;
    logic signed [XW-1:0] half;
    logic signed [XW-1:0] hr;
    logic signed [XW-1:0] sv [4];
    logic signed [XW-1:0] m [4];
    logic                 in_pyr;
    logic [1:0]           best;
    ady  = dy[XW-1] ? -dy : dy;
    half = ux(cfg.length >> 1);
    hr   = half + ux(cfg.radius);
    sv[0] = dx + qy;
    sv[1] = qy - dx;
    sv[2] = qy + dz;
    sv[3] = qy - dz;
    in_pyr = (dy > 0);
    for (int i = 0; i < 4; i++) begin
      m[i] = -sv[i];
      if (!sv[i][XW-1]) begin
        in_pyr = 1'b0;
      end
    end
    best = 2'd0;
    for (int i = 1; i < 4; i++) begin
      if (m[i] < m[best]) begin
        best = 2'(i);
      end
    end
    job.px   = fx;
    job.py   = fy;
    job.pz   = fz;
    job.best = best;
    job.by   = dy[UW-1:0];
    job.s    = m[best][COORD_W-1:0];
    case (cfg.kind)
      KIND_SPHERE: job.op = OP_SPHERE;
      KIND_CAPSULE: begin
        if (ady <= half) begin
          job.op = OP_CAP_SIDE;
        end else if (ady <= hr) begin
          job.op = OP_CAP_END;
        end else begin
          job.op = OP_PASS;
        end
      end
      KIND_PYRAMID: job.op = in_pyr ? OP_PYR : OP_PASS;
      default: job.op = OP_PASS;
    endcase
  end

endmodule

[src/pobp_back.sv]
module pobp_back (
  input  logic                                clk,
  input  logic                                rst,
  input  pobp_pkg::cfg_t                      cfg,
  input  pobp_pkg::job_t                      job,
  input  logic                                empty,
  output logic                                pop,
  output logic signed [pobp_pkg::COORD_W-1:0] new_x,
  output logic signed [pobp_pkg::COORD_W-1:0] new_y,
  output logic signed [pobp_pkg::COORD_W-1:0] new_z,
  output logic                                moved,
  output logic                                degenerate,
  output logic                                out_valid,
  input  logic                                out_stall
);
  import pobp_pkg::*;

  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(UW - 1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(NUM_W - 1);

  back_state_t state, state_next;

  op_t                  op;
  phase_t               phase;
  logic [1:0]           best;
  logic [UW-1:0]        pby;
  logic [COORD_W-1:0]   ps;
  logic signed [XW-1:0] p  [3];
  logic signed [XW-1:0] ce [3];
  logic signed [XW-1:0] d  [3];
  logic [UW-1:0]        dm [3];
  logic                 far;
  logic                 two_d;
  logic                 incl;
  logic                 chk;
  logic [1:0]           mcnt;
  logic [1:0]           axis;
  logic [CNT_W-1:0]     cnt;
  logic [PW-1:0]        r2, l2, b2, s2;
  logic [PW-1:0]        sq_num, sq_res, sq_bit;
  logic [UW-1:0]        len;
  logic [NUM_W-1:0]     num;
  logic [COORD_W-1:0]   rem;
  logic [COORD_W-1:0]   q;
  logic                 f_moved, f_degen;
  logic                 res_valid;
  logic                 res_load;

  // ball setup for the current phase
  logic                 two_d_c;
  logic signed [XW-1:0] half_c;
  logic signed [XW-1:0] ce_c [3];

  always_comb begin
    two_d_c = (op == OP_CAP_SIDE) || (op == OP_CAP_END && phase == PH_FIRST);
    half_c  = ux(cfg.length >> 1);
    ce_c[0] = sx(cfg.cx);
    ce_c[2] = sx(cfg.cz);
    case (phase)
      PH_TOP:  ce_c[1] = sx(cfg.cy) + half_c;
      PH_BOT:  ce_c[1] = sx(cfg.cy) - half_c;
      default: ce_c[1] = sx(cfg.cy);
    endcase
  end

  // shared multiplier
  logic [1:0]         mul_idx;
  logic [COORD_W-1:0] mul_a, mul_b;
  logic [PW-1:0]      prod;

  assign mul_idx = (state == B_SQ) ? (mcnt - 2'd1) : axis;

  always_comb begin
    case (state)
      B_SQ: begin
        if (mcnt == 2'd0) begin
          mul_a = {1'b0, cfg.radius};
        end else if (mcnt == 2'd2 && two_d) begin
          mul_a = '0;
        end else begin
          mul_a = {1'b0, dm[mul_idx]};
        end
        mul_b = mul_a;
      end
      B_MUL: begin
        mul_a = {1'b0, dm[mul_idx]};
        mul_b = {1'b0, cfg.radius};
      end
      B_PMUL0: begin
        mul_a = {1'b0, pby};
        mul_b = {1'b0, pby};
      end
      B_PMUL1: begin
        mul_a = ps;
        mul_b = ps;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // square root step, divider step, rounding
  logic [PW-1:0]        sq_t;
  logic                 sq_ge;
  logic [PW-1:0]        sq_res_next;
  logic [COORD_W-1:0]   ulen;
  logic [COORD_W-1:0]   rem_sh;
  logic                 div_ge;
  logic                 rnd_up;
  logic signed [XW-1:0] qr;
  logic signed [XW-1:0] hx;
  logic [COORD_W:0]     s_inc;
  logic                 inside_c;
  logic                 base_near;

  assign sq_t        = sq_res + sq_bit;
  assign sq_ge       = (sq_num >= sq_t);
  assign sq_res_next = sq_ge ? ((sq_res >> 1) + sq_bit) : (sq_res >> 1);
  assign ulen        = {1'b0, len};
  assign rem_sh      = {rem[COORD_W-2:0], num[NUM_W-1]};
  assign div_ge      = (rem_sh >= ulen);
  assign rnd_up      = (rem >= (ulen - rem));
  assign qr          = $signed({{(XW-COORD_W){1'b0}}, q}) + $signed({{(XW-1){1'b0}}, rnd_up});
  assign s_inc       = {1'b0, ps} + 1'b1;
  assign hx          = $signed({{(XW-COORD_W){1'b0}}, s_inc[COORD_W:1]});
  assign inside_c    = !far && (incl ? (l2 <= r2) : (l2 < r2));
  assign base_near   = ({b2, 1'b0} < {1'b0, s2});

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!empty) begin
          case (job.op)
            OP_PASS: state_next = B_DONE;
            OP_PYR:  state_next = B_PMUL0;
            default: state_next = B_SETUP;
          endcase
        end
      end
      B_SETUP: state_next = B_MAG;
      B_MAG:   state_next = B_SQ;
      B_SQ: begin
        if (mcnt == 2'd3) begin
          state_next = B_CHECK;
        end
      end
      B_CHECK: begin
        if (chk) begin
          state_next = inside_c ? B_SETUP : B_DONE;
        end else if (!inside_c || l2 == '0) begin
          state_next = B_BEND;
        end else begin
          state_next = B_SQRT;
        end
      end
      B_SQRT: begin
        if (cnt == SQRT_LAST) begin
          state_next = B_MUL;
        end
      end
      B_MUL: state_next = B_DIV;
      B_DIV: begin
        if (cnt == DIV_LAST) begin
          state_next = B_ROUND;
        end
      end
      B_ROUND: state_next = (axis == 2'd2) ? B_BEND : B_MUL;
      B_BEND: begin
        if (op == OP_CAP_END && phase == PH_TOP) begin
          state_next = B_SETUP;
        end else begin
          state_next = B_DONE;
        end
      end
      B_PMUL0: state_next = B_PMUL1;
      B_PMUL1: state_next = B_PDEC;
      B_PDEC:  state_next = B_DONE;
      B_DONE: begin
        if (!res_valid || !out_stall) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    pop      = (state == B_IDLE) && !empty;
    res_load = (state == B_DONE) && (!res_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!out_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (!empty) begin
          op      <= job.op;
          best    <= job.best;
          pby     <= job.by;
          ps      <= job.s;
          p[0]    <= sx(job.px);
          p[1]    <= sx(job.py);
          p[2]    <= sx(job.pz);
          phase   <= PH_FIRST;
          f_moved <= 1'b0;
          f_degen <= 1'b0;
        end
      end
      B_SETUP: begin
        for (int i = 0; i < 3; i++) begin
          ce[i] <= ce_c[i];
          d[i]  <= p[i] - ce_c[i];
        end
        two_d <= two_d_c;
        incl  <= two_d_c;
        chk   <= (op == OP_CAP_END && phase == PH_FIRST);
      end
      B_MAG: begin
        logic signed [XW-1:0] mg [3];
        logic                 big;
        big = 1'b0;
        for (int i = 0; i < 3; i++) begin
          mg[i] = d[i][XW-1] ? -d[i] : d[i];
          dm[i] <= mg[i][UW-1:0];
          if ((i != 1 || !two_d) && (|mg[i][XW-1:UW])) begin
            big = 1'b1;
          end
        end
        far  <= big;
        mcnt <= 2'd0;
        l2   <= '0;
      end
      B_SQ: begin
        mcnt <= mcnt + 2'd1;
        if (mcnt == 2'd0) begin
          r2 <= prod;
        end else begin
          l2 <= l2 + prod;
        end
      end
      B_CHECK: begin
        if (chk) begin
          phase <= PH_TOP;
        end else if (inside_c && l2 == '0) begin
          f_degen <= 1'b1;
        end
        sq_num <= l2;
        sq_res <= '0;
        sq_bit <= PW'(1) << (2 * (UW - 1));
        cnt    <= '0;
        axis   <= 2'd0;
      end
      B_SQRT: begin
        if (sq_ge) begin
          sq_num <= sq_num - sq_t;
        end
        sq_res <= sq_res_next;
        sq_bit <= sq_bit >> 2;
        cnt    <= cnt + 1'b1;
        if (cnt == SQRT_LAST) begin
          len <= sq_res_next[UW-1:0];
        end
      end
      B_MUL: begin
        num <= prod[NUM_W-1:0];
        rem <= '0;
        q   <= '0;
        cnt <= '0;
      end
      B_DIV: begin
        rem <= div_ge ? (rem_sh - ulen) : rem_sh;
        q   <= {q[COORD_W-2:0], div_ge};
        num <= num << 1;
        cnt <= cnt + 1'b1;
      end
      B_ROUND: begin
        p[axis] <= d[axis][XW-1] ? (ce[axis] - qr) : (ce[axis] + qr);
        if (axis == 2'd0) begin
          axis <= two_d ? 2'd2 : 2'd1;
        end else begin
          axis <= 2'd2;
        end
        if (axis == 2'd2) begin
          f_moved <= 1'b1;
        end
      end
      B_BEND: begin
        if (op == OP_CAP_END && phase == PH_TOP) begin
          phase <= PH_BOT;
        end
      end
      B_PMUL0: b2 <= prod;
      B_PMUL1: s2 <= prod;
      B_PDEC: begin
        f_moved <= 1'b1;
        if (base_near) begin
          p[1] <= sx(cfg.cy);
        end else begin
          p[1] <= p[1] + hx;
          case (best)
            2'd0:    p[0] <= p[0] + hx;
            2'd1:    p[0] <= p[0] - hx;
            2'd2:    p[2] <= p[2] + hx;
            default: p[2] <= p[2] - hx;
          endcase
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (res_load) begin
      new_x      <= sat(p[0]);
      new_y      <= sat(p[1]);
      new_z      <= sat(p[2]);
      moved      <= f_moved;
      degenerate <= f_degen;
    end
  end

  assign out_valid = res_valid;

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == B_SQRT && cnt == SQRT_LAST) |=> (len != '0))
    else $error("zero root on a nonzero length");
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == B_ROUND) |-> (rem < ulen)) else $error("divider remainder out of range");
  a_pop_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state != B_IDLE)) else $error("job popped but sequencer stayed idle");

endmodule

[src/particle_obstacle_pushout_core.sv]
// channel | direction | handshake           | word
// in      | to core   | in_valid / in_stall   | pos_x, pos_y, pos_z
// out     | from core | out_valid / out_stall | new_x, new_y, new_z, moved, degenerate
// cfg     | to core   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A pass-through word (outside the obstacle band) skips the square root and divider,
// as does a pyramid push. A sphere push is set by the one-bit-a-cycle square root
// (31 steps) and the restoring divider (62 steps per axis) in the back sequencer;
// a capsule end push runs two spheres.
// The front keeps taking words into a 4-deep queue while the back works.
// rst is synchronous; after reset the obstacle is a unit sphere at the origin.
// A stalled output word holds; the back finishes the next word and waits for it.
module particle_obstacle_pushout_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic signed [pobp_pkg::COORD_W-1:0] pos_x,
  input  logic signed [pobp_pkg::COORD_W-1:0] pos_y,
  input  logic signed [pobp_pkg::COORD_W-1:0] pos_z,
  input  logic                                in_valid,
  output logic                                in_stall,
  output logic signed [pobp_pkg::COORD_W-1:0] new_x,
  output logic signed [pobp_pkg::COORD_W-1:0] new_y,
  output logic signed [pobp_pkg::COORD_W-1:0] new_z,
  output logic                                moved,
  output logic                                degenerate,
  output logic                                out_valid,
  input  logic                                out_stall,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pobp_pkg::IDX_W-1:0]          cfg_index,
  input  logic [pobp_pkg::COORD_W-1:0]        cfg_data
);
  import pobp_pkg::*;

  cfg_t cfg;
  job_t f_job;
  job_t q_job;
  logic f_push;
  logic q_full;
  logic q_empty;
  logic b_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kind   <= KIND_SPHERE;
      cfg.cx     <= '0;
      cfg.cy     <= '0;
      cfg.cz     <= '0;
      cfg.radius <= UW'(1) << FRAC_BITS;
      cfg.length <= UW'(2) << FRAC_BITS;
      cfg.scale  <= UW'(1) << FRAC_BITS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_KIND:   cfg.kind   <= kind_t'(cfg_data[1:0]);
        CFG_CX:     cfg.cx     <= cfg_data;
        CFG_CY:     cfg.cy     <= cfg_data;
        CFG_CZ:     cfg.cz     <= cfg_data;
        CFG_RADIUS: cfg.radius <= cfg_data[UW-1:0];
        CFG_LENGTH: cfg.length <= cfg_data[UW-1:0];
        CFG_SCALE:  cfg.scale  <= cfg_data[UW-1:0];
        default: ;
      endcase
    end
  end

  pobp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .pos_z    (pos_z),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .full     (q_full),
    .push     (f_push),
    .job      (f_job)
  );

  pobp_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .wdata (f_job),
    .pop   (b_pop),
    .rdata (q_job),
    .empty (q_empty),
    .full  (q_full)
  );

  pobp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .job        (q_job),
    .empty      (q_empty),
    .pop        (b_pop),
    .new_x      (new_x),
    .new_y      (new_y),
    .new_z      (new_z),
    .moved      (moved),
    .degenerate (degenerate),
    .out_valid  (out_valid),
    .out_stall  (out_stall)
  );

endmodule
